// ===== sv/register_alu_with_stack_macros.svh =====
// Assertion macros for the register ALU with stack.
`ifndef REGISTER_ALU_WITH_STACK_MACROS_SVH
`define REGISTER_ALU_WITH_STACK_MACROS_SVH
`define RAWS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/raws_pkg.sv =====
// Package with opcodes and error codes for the register ALU with stack.
`default_nettype none
package raws_pkg;
    localparam int OP_W = 5;
    localparam int ERR_W = 2;
    localparam logic [OP_W-1:0] OP_AND = 5'd0;
    localparam logic [OP_W-1:0] OP_OR = 5'd1;
    localparam logic [OP_W-1:0] OP_NOT = 5'd2;
    localparam logic [OP_W-1:0] OP_ADD = 5'd3;
    localparam logic [OP_W-1:0] OP_SUB = 5'd4;
    localparam logic [OP_W-1:0] OP_MUL = 5'd5;
    localparam logic [OP_W-1:0] OP_DIV = 5'd6;
    localparam logic [OP_W-1:0] OP_MOD = 5'd7;
    localparam logic [OP_W-1:0] OP_INC = 5'd8;
    localparam logic [OP_W-1:0] OP_DEC = 5'd9;
    localparam logic [OP_W-1:0] OP_SHR = 5'd10;
    localparam logic [OP_W-1:0] OP_SHL = 5'd11;
    localparam logic [OP_W-1:0] OP_PUSH = 5'd12;
    localparam logic [OP_W-1:0] OP_POP = 5'd13;
    localparam logic [OP_W-1:0] OP_PEEK = 5'd14;
    localparam logic [OP_W-1:0] OP_PEEKN = 5'd15;
    localparam logic [ERR_W-1:0] ERR_OK = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV0 = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL = 2'd2;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd3;
    typedef logic [OP_W-1:0] t_op;
    typedef logic [ERR_W-1:0] t_err;
    typedef struct packed {
        logic start;
        logic is_mod;
    } t_div_ctl;
endpackage
`default_nettype wire

// ===== sv/raws_if.sv =====
// Valid/ready channel interfaces for instruction and result beats.
`default_nettype none
interface raws_in_if #(parameter int REG_IDX_W = 4);
    logic valid;
    logic ready;
    logic [4:0] op;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [REG_IDX_W-1:0] src_reg;
    logic [5:0] amount;
    modport source(output valid, op, dest_reg, src_reg, amount, input ready);
    modport sink(input valid, op, dest_reg, src_reg, amount, output ready);
endinterface

interface raws_out_if #(parameter int DATA_WIDTH = 32);
    logic valid;
    logic ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic [1:0] error;
    modport source(output valid, value, error, input ready);
    modport sink(input valid, value, error, output ready);
endinterface
`default_nettype wire

// ===== sv/raws_alu.sv =====
// Shared iterative unit: shift-subtract divider and shift-add multiplier.
`default_nettype none
module raws_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  raws_pkg::t_div_ctl        i_ctl,
    input  wire                       i_mul,
    input  wire  [DATA_WIDTH-1:0]     i_a,
    input  wire  [DATA_WIDTH-1:0]     i_b,
    output logic                      o_done,
    output logic [DATA_WIDTH-1:0]     o_result
);
    import raws_pkg::*;
    localparam int CW = $clog2(DATA_WIDTH + 1);
    logic [DATA_WIDTH-1:0] r_q, n_q, r_d, n_d, r_acc, n_acc;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_busy, n_busy, r_mul, n_mul, r_ngq, n_ngq, r_ngr, n_ngr, r_mod, n_mod;
    logic [DATA_WIDTH:0]   w_try;
    logic [DATA_WIDTH-1:0] w_ma, w_mb, w_qs, w_rs;

    assign w_ma = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_mb = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign w_try = {r_rem, r_q[DATA_WIDTH-1]} - {1'b0, r_d};
    assign w_qs = r_ngq ? (~r_q + 1'b1) : r_q;
    assign w_rs = r_ngr ? (~r_rem + 1'b1) : r_rem;

    always_comb begin
        n_q = r_q; n_d = r_d; n_acc = r_acc; n_rem = r_rem; n_cnt = r_cnt;
        n_busy = r_busy; n_mul = r_mul; n_ngq = r_ngq; n_ngr = r_ngr; n_mod = r_mod;
        o_done = 1'b0;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_mul = i_mul;
            n_mod = i_ctl.is_mod;
            n_cnt = CW'(DATA_WIDTH);
            n_rem = '0;
            n_acc = '0;
            n_q = i_mul ? i_a : w_ma;
            n_d = i_mul ? i_b : w_mb;
            n_ngq = i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
            n_ngr = i_a[DATA_WIDTH-1];
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
                if (r_mul) begin
                    n_acc = r_q[0] ? r_acc + r_d : r_acc;
                    n_q = r_q >> 1;
                    n_d = r_d << 1;
                end else if (!w_try[DATA_WIDTH]) begin
                    n_rem = w_try[DATA_WIDTH-1:0];
                    n_q = {r_q[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[DATA_WIDTH-2:0], r_q[DATA_WIDTH-1]};
                    n_q = {r_q[DATA_WIDTH-2:0], 1'b0};
                end
            end
        end
        o_result = r_mul ? r_acc : (r_mod ? w_rs : w_qs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_q <= n_q; r_d <= n_d; r_acc <= n_acc; r_rem <= n_rem; r_cnt <= n_cnt;
        r_mul <= n_mul; r_ngq <= n_ngq; r_ngr <= n_ngr; r_mod <= n_mod;
    end
endmodule
`default_nettype wire

// ===== sv/register_alu_with_stack.sv =====
// Top level of the two-operand register ALU with a value stack.
//   channel | dir | beat contents
//   i_in    | in  | op, dest_reg, src_reg, amount
//   o_out   | out | value, error
// A beat passes through S_RD, S_EXE and S_OUT; MUL, DIV and MOD (a zero divisor excepted)
// also wait in S_ITER for the shared shift-add/subtract unit.
// Stack reads pass through the extra state S_STK for the registered memory port.
// Reset clears the register file in the state S_CLR, during which no beat is taken.
// A stalled result holds the block; the next beat is taken once it leaves.
`default_nettype none
module register_alu_with_stack #(
    parameter int NUM_REGS = 16,
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH = 32
) (
    input wire i_clk,
    input wire i_rst_n,
    raws_in_if.sink i_in,
    raws_out_if.source o_out
);
    import raws_pkg::*;
    `include "register_alu_with_stack_macros.svh"
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_EXE = 3'd3,
        S_ITER = 3'd4, S_STK = 3'd5, S_OUT = 3'd6;

    function automatic logic [RW-1:0] wrap_idx(input logic [3:0] idx);
        logic [9:0] v;
        v = {6'd0, idx};
        for (int k = 3; k >= 0; k--) begin
            if (v >= 10'(NUM_REGS << k)) v = v - 10'(NUM_REGS << k);
        end
        return RW'(v);
    endfunction

    logic [DATA_WIDTH-1:0] r_regs [NUM_REGS];
    logic [DATA_WIDTH-1:0] r_stack [STACK_DEPTH];
    logic [2:0] r_state, n_state;
    logic [RW-1:0] r_clr;
    logic [CW-1:0] r_cnt, n_cnt;
    t_op r_op;
    logic [RW-1:0] r_d, r_s;
    logic [5:0] r_amt;
    logic [DATA_WIDTH-1:0] r_a, r_b, r_val, n_val, r_sdata;
    t_err r_err, n_err;
    logic w_swe, w_rwe;
    logic [SW-1:0] w_sra;
    logic [CW-1:0] w_idx;
    t_div_ctl w_ctl;
    logic w_done;
    logic [DATA_WIDTH-1:0] w_ures, w_shr, w_shl;

    raws_alu #(.DATA_WIDTH(DATA_WIDTH)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_mul(r_op == OP_MUL),
        .i_a(r_a), .i_b(r_b), .o_done(w_done), .o_result(w_ures));

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.value = r_val;
    assign o_out.error = r_err;
    assign w_shr = ({1'b0, r_amt} >= 7'(DATA_WIDTH)) ? {DATA_WIDTH{r_a[DATA_WIDTH-1]}}
                   : DATA_WIDTH'($signed(r_a) >>> r_amt);
    assign w_shl = ({1'b0, r_amt} >= 7'(DATA_WIDTH)) ? '0 : (r_a << r_amt);
    assign w_idx = r_cnt - CW'(1) - ((r_op == OP_PEEKN) ? CW'(r_amt) : CW'(0));
    assign w_sra = w_idx[SW-1:0];

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_val = r_val; n_err = r_err;
        w_swe = 1'b0; w_rwe = 1'b0;
        w_ctl = '{start: 1'b0, is_mod: r_op == OP_MOD};
        unique case (r_state)
            S_CLR: if (r_clr == RW'(NUM_REGS - 1)) n_state = S_IDLE;
            S_IDLE: if (i_in.valid) n_state = S_RD;
            S_RD: n_state = S_EXE;
            S_EXE: begin
                n_err = ERR_OK;
                n_val = r_a;
                n_state = S_OUT;
                case (r_op)
                    OP_AND: n_val = r_a & r_b;
                    OP_OR: n_val = r_a | r_b;
                    OP_NOT: n_val = ~r_a;
                    OP_ADD: n_val = r_a + r_b;
                    OP_SUB: n_val = r_a - r_b;
                    OP_INC: n_val = r_a + 1'b1;
                    OP_DEC: n_val = r_a - 1'b1;
                    OP_SHR: n_val = w_shr;
                    OP_SHL: n_val = w_shl;
                    OP_MUL: begin
                        w_ctl.start = 1'b1; n_state = S_ITER;
                    end
                    OP_DIV, OP_MOD: begin
                        if (r_b == '0) begin
                            n_err = ERR_DIV0; n_val = '0;
                        end else begin
                            w_ctl.start = 1'b1; n_state = S_ITER;
                        end
                    end
                    OP_PUSH: begin
                        if (r_cnt == CW'(STACK_DEPTH)) begin
                            n_err = ERR_FULL; n_val = '0;
                        end else begin
                            w_swe = 1'b1; n_cnt = r_cnt + 1'b1;
                        end
                    end
                    OP_POP, OP_PEEK, OP_PEEKN: begin
                        if ((r_op == OP_PEEKN && CW'(r_amt) >= r_cnt) || r_cnt == '0
                            || (r_op == OP_PEEKN && r_amt >= 6'(STACK_DEPTH)
                                && STACK_DEPTH < 64)) begin
                            n_err = ERR_EMPTY; n_val = '0;
                        end else begin
                            n_state = S_STK;
                        end
                    end
                    default: n_val = r_a;
                endcase
                if (n_state == S_OUT && n_err == ERR_OK) w_rwe = 1'b1;
            end
            S_ITER: if (w_done) begin
                n_val = w_ures; w_rwe = 1'b1; n_state = S_OUT;
            end
            S_STK: begin
                n_val = r_sdata; w_rwe = 1'b1; n_state = S_OUT;
                if (r_op == OP_POP) n_cnt = r_cnt - 1'b1;
            end
            S_OUT: if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            if (r_state == S_CLR) r_clr <= r_clr + 1'b1;
        end
        if (r_state == S_CLR) r_regs[r_clr] <= '0;
        else if (w_rwe) r_regs[r_d] <= n_val;
        if (i_in.valid && i_in.ready) begin
            r_op <= i_in.op;
            r_d <= wrap_idx(i_in.dest_reg);
            r_s <= wrap_idx(i_in.src_reg);
            r_amt <= i_in.amount;
        end
        if (r_state == S_RD) begin
            r_a <= r_regs[r_d];
            r_b <= r_regs[r_s];
        end
        if (w_swe) r_stack[r_cnt[SW-1:0]] <= r_a;
        r_sdata <= r_stack[w_sra];
        r_val <= n_val;
        r_err <= n_err;
    end

    `RAWS_ASSERT_IMPL(a_excl, i_clk, i_rst_n, 1'b1, !(i_in.ready && o_out.valid))
    `RAWS_ASSERT_IMPL(a_cnt, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(STACK_DEPTH))
    `RAWS_ASSERT_IMPL(a_zero, i_clk, i_rst_n, o_out.valid && r_err != ERR_OK, r_val == '0)
    `RAWS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, $stable({r_val, r_err}))
endmodule
`default_nettype wire
